### hdl/assert_macros.svh
// Assertion helpers used by refcounted_block_pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define RBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define RBP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

### hdl/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Types, codes and fixed widths of the reference-counted block pool.
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

    // Fixed field widths
    localparam int KIND_W       = 2;
    localparam int BLOCK_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int OFFSET_W     = 21;
    localparam int REF_OUT_W    = 8;
    localparam int ERR_W        = 32;
    localparam int POOL_W       = 9;
    localparam int ITEM_BYTES_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_BLOCKS = 256;
    localparam int DEF_REF_BITS   = 8;
    localparam int DEF_META_WORDS = 2;

    // Register values after reset
    localparam int RST_POOL_BLOCKS = 256;
    localparam int RST_ITEM_BYTES  = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_INCR    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NOP     = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZERO  = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BLOCKS = 1'b0,
        CFG_ITEM_BYTES  = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

### hdl/rbp_if.sv
// ----------------------------------------------------------------------------
// rbp_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbp_in_if import rbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BLOCK_W-1:0] block;

    modport source (output valid, output kind, output block, input ready);
    modport sink   (input valid, input kind, input block, output ready);
endinterface

interface rbp_out_if import rbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [BLOCK_W-1:0]   block_index;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [REF_OUT_W-1:0] ref_after;
    logic                 released;
    logic [ERR_W-1:0]     error_count;

    modport source (output valid, output status, output block_index, output byte_offset,
                    output ref_after, output released, output error_count, input ready);
    modport sink   (input valid, input status, input block_index, input byte_offset,
                    input ref_after, input released, input error_count, output ready);
endinterface

`default_nettype wire

### hdl/refcounted_block_pool.sv
// ----------------------------------------------------------------------------
// refcounted_block_pool
// Pool of equal blocks on a LIFO free list, with a reference count per block.
// ----------------------------------------------------------------------------
// An accepted item enters the execute stage, where the memories are read at
// the accepting edge; the update and the result are registered as it hands on.
// Throughput: one item per cycle while results are taken; the registered read
// of the count and link memories sets the latency, forwarding keeps the rate.
// Reset is synchronous; no clearing pass is run, so the block accepts items
// as soon as reset is released.
`default_nettype none
`include "assert_macros.svh"

module refcounted_block_pool import rbp_pkg::*; #(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
    parameter int REF_BITS   = DEF_REF_BITS,
    parameter int META_WORDS = DEF_META_WORDS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rbp_in_if.sink                     i_item,
    rbp_out_if.source                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Index of a block, and a count that can hold the number of blocks itself.
    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int LINK_W  = IDX_W + 1;
    localparam int EXT_W   = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;
    localparam int EXTP_W  = EXT_W + 1;
    localparam int RX_W    = (REF_BITS > REF_OUT_W) ? REF_BITS : REF_OUT_W;
    localparam int RST_CNT = (RST_POOL_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : RST_POOL_BLOCKS;

    // ------------------------------------------------------------------------
    // Free list bookkeeping.
    //
    // The free list is the chain of blocks pushed back by releases, followed
    // by the untouched blocks from the watermark up to the pool size. A block
    // at or above the watermark has never been allocated since the list was
    // rebuilt, so its count is zero and its link is simply the next index.
    // Blocks below the watermark have had their count written, so the count
    // memory is only believed below the watermark. This gives the behaviour
    // of a freshly cleared pool without sweeping either memory.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_wm;
    logic [IDX_W-1:0]        r_head;
    logic                    r_head_v;
    logic [ITEM_BYTES_W-1:0] r_item_bytes;
    logic [ERR_W-1:0]        r_err;

    logic [CNT_W-1:0]        n_wm;
    logic [IDX_W-1:0]        n_head;
    logic                    n_head_v;
    logic [ERR_W-1:0]        n_err;

    // Execute stage: the item whose memory reads are under way.
    logic                    r_exe_v;
    t_kind                   r_kind;
    logic [BLOCK_W-1:0]      r_blk;

    // Forwarding of a write that hit the entry being read at the same edge.
    logic                    r_ref_fwd;
    logic [REF_BITS-1:0]     r_ref_fwd_d;
    logic                    r_link_fwd;
    logic [LINK_W-1:0]       r_link_fwd_d;

    // Result register
    logic                    r_out_v;
    logic [STATUS_W-1:0]     r_status;
    logic [BLOCK_W-1:0]      r_index;
    logic [OFFSET_W-1:0]     r_offset;
    logic [REF_OUT_W-1:0]    r_ref_after;
    logic                    r_released;
    logic [ERR_W-1:0]        r_err_out;

    // Memory ports
    logic                    ref_we;
    logic [IDX_W-1:0]        ref_waddr;
    logic [REF_BITS-1:0]     ref_wdata;
    logic [IDX_W-1:0]        ref_raddr;
    logic [REF_BITS-1:0]     ref_rdata;
    logic                    link_we;
    logic [IDX_W-1:0]        link_waddr;
    logic [LINK_W-1:0]       link_wdata;
    logic [LINK_W-1:0]       link_rdata;

    logic                    in_fire;
    logic                    exe_done;
    logic                    pool_wr;

    // Execute stage working values
    logic [EXT_W-1:0]        in_blk_ext;
    logic [EXT_W-1:0]        blk_ext;
    logic [IDX_W-1:0]        blk_idx;
    logic                    blk_in_range;
    logic                    blk_touched;
    logic [REF_BITS-1:0]     ref_cur;
    logic [REF_BITS-1:0]     ref_new;
    logic [LINK_W-1:0]       link_cur;
    logic                    head_untouched;
    logic [CNT_W-1:0]        wm_inc;
    logic [EXT_W-1:0]        head_ext;
    logic [RX_W-1:0]         ref_ext;
    t_status                 n_status;
    logic [BLOCK_W-1:0]      n_index;
    logic [REF_BITS-1:0]     n_ref;
    logic                    n_released;
    logic                    n_offset_zero;
    logic [OFFSET_W-1:0]     offset_raw;

    logic [31:0]             pool_req;
    logic [31:0]             pool_clamp;

    // ------------------------------------------------------------------------
    // Handshake. An item moves into the execute stage whenever that stage is
    // empty or hands its result on in the same cycle; the result register
    // parts the execute stage from the consumer.
    // ------------------------------------------------------------------------
    assign exe_done     = r_exe_v && (!r_out_v || o_result.ready);
    assign i_item.ready = !r_exe_v || exe_done;
    assign in_fire      = i_item.valid && i_item.ready;

    // A write of the pool size rebuilds the free list.
    assign pool_wr      = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_POOL_BLOCKS);

    assign o_result.valid       = r_out_v;
    assign o_result.status      = r_status;
    assign o_result.block_index = r_index;
    assign o_result.byte_offset = r_offset;
    assign o_result.ref_after   = r_ref_after;
    assign o_result.released    = r_released;
    assign o_result.error_count = r_err_out;

    // Read addresses are formed at acceptance. The link read uses the head as
    // it stands after the item now finishing, so that a push followed at once
    // by a pop reads the right entry (through the forwarding path).
    assign in_blk_ext = EXT_W'(i_item.block);
    assign ref_raddr  = in_blk_ext[IDX_W-1:0];

    rbp_ram #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (REF_BITS)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_re    (in_fire),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    rbp_ram #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (in_fire),
        .i_raddr (n_head),
        .o_rdata (link_rdata)
    );

    rbp_offset #(
        .META_WORDS (META_WORDS)
    ) u_offset (
        .i_index      (n_index),
        .i_item_bytes (r_item_bytes),
        .o_offset     (offset_raw)
    );

    // ------------------------------------------------------------------------
    // Execute: read-modify-write of the count and link memories.
    // ------------------------------------------------------------------------
    always_comb begin
        blk_ext        = EXT_W'(r_blk);
        blk_idx        = blk_ext[IDX_W-1:0];
        blk_in_range   = EXTP_W'(r_blk) < EXTP_W'(NUM_BLOCKS);
        blk_touched    = blk_in_range && (CNT_W'(blk_idx) < r_wm);
        ref_cur        = r_ref_fwd ? r_ref_fwd_d : ref_rdata;
        if (!blk_touched) begin
            ref_cur = '0;
        end
        link_cur       = r_link_fwd ? r_link_fwd_d : link_rdata;
        head_untouched = (CNT_W'(r_head) == r_wm);
        wm_inc         = r_wm + CNT_W'(1);
        head_ext       = EXT_W'(r_head);
        ref_new        = ref_cur;

        n_wm           = r_wm;
        n_head         = r_head;
        n_head_v       = r_head_v;
        n_err          = r_err;
        n_status       = ST_OK;
        n_index        = r_blk;
        n_ref          = ref_cur;
        n_released     = 1'b0;
        n_offset_zero  = 1'b0;

        ref_we         = 1'b0;
        ref_waddr      = blk_idx;
        ref_wdata      = ref_new;
        link_we        = 1'b0;
        link_waddr     = blk_idx;
        link_wdata     = {r_head_v, r_head};

        case (r_kind)
            KIND_ALLOC: begin
                if (r_head_v) begin
                    n_index   = head_ext[BLOCK_W-1:0];
                    n_ref     = REF_BITS'(1);
                    ref_we    = 1'b1;
                    ref_waddr = r_head;
                    ref_wdata = REF_BITS'(1);
                    if (head_untouched) begin
                        // Next block of the untouched range.
                        n_wm     = wm_inc;
                        n_head   = wm_inc[IDX_W-1:0];
                        n_head_v = wm_inc < r_count;
                    end else begin
                        n_head   = link_cur[IDX_W-1:0];
                        n_head_v = link_cur[IDX_W];
                    end
                end else begin
                    n_status      = ST_EMPTY;
                    n_err         = r_err + ERR_W'(1);
                    n_index       = '0;
                    n_ref         = '0;
                    n_offset_zero = 1'b1;
                end
            end
            KIND_INCR: begin
                if (ref_cur == '0) begin
                    n_status = ST_ZERO;
                end else if (ref_cur == '1) begin
                    n_status = ST_SAT;
                end else begin
                    ref_new   = ref_cur + REF_BITS'(1);
                    n_ref     = ref_new;
                    ref_we    = 1'b1;
                    ref_wdata = ref_new;
                end
            end
            KIND_RELEASE: begin
                if (ref_cur == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    ref_new   = ref_cur - REF_BITS'(1);
                    n_ref     = ref_new;
                    ref_we    = 1'b1;
                    ref_wdata = ref_new;
                    if (ref_new == '0) begin
                        // Last reference gone: push the block onto the list.
                        link_we    = 1'b1;
                        n_head     = blk_idx;
                        n_head_v   = 1'b1;
                        n_released = 1'b1;
                    end
                end
            end
            default: begin
                // No operation: report the block and its present count.
            end
        endcase

        if (!exe_done) begin
            n_wm     = r_wm;
            n_head   = r_head;
            n_head_v = r_head_v;
            n_err    = r_err;
            ref_we   = 1'b0;
            link_we  = 1'b0;
        end

        ref_ext = RX_W'(n_ref);
    end

    // Pool size as written, with zero taken as one and a cap at the depth.
    always_comb begin
        pool_req = 32'(i_cfg_data[POOL_W-1:0]);
        if (pool_req == 32'd0) begin
            pool_clamp = 32'd1;
        end else if (pool_req > 32'(NUM_BLOCKS)) begin
            pool_clamp = 32'(NUM_BLOCKS);
        end else begin
            pool_clamp = pool_req;
        end
    end

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= CNT_W'(RST_CNT);
            r_wm         <= '0;
            r_head       <= '0;
            r_head_v     <= 1'b1;
            r_item_bytes <= ITEM_BYTES_W'(RST_ITEM_BYTES);
            r_err        <= '0;
            r_exe_v      <= 1'b0;
            r_out_v      <= 1'b0;
            r_ref_fwd    <= 1'b0;
            r_link_fwd   <= 1'b0;
        end else begin
            r_err <= n_err;

            if (pool_wr) begin
                // Rebuild the list: everything becomes untouched again.
                r_wm     <= '0;
                r_head   <= '0;
                r_head_v <= 1'b1;
            end else begin
                r_wm     <= n_wm;
                r_head   <= n_head;
                r_head_v <= n_head_v;
            end

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_POOL_BLOCKS: begin
                        r_count <= CNT_W'(pool_clamp);
                    end
                    CFG_ITEM_BYTES: begin
                        r_item_bytes <= i_cfg_data[ITEM_BYTES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (in_fire) begin
                r_exe_v    <= 1'b1;
                r_ref_fwd  <= ref_we && (ref_waddr == ref_raddr);
                r_link_fwd <= link_we && (link_waddr == n_head);
            end else if (exe_done) begin
                r_exe_v <= 1'b0;
            end

            if (exe_done) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind       <= t_kind'(i_item.kind);
            r_blk        <= i_item.block;
            r_ref_fwd_d  <= ref_wdata;
            r_link_fwd_d <= link_wdata;
        end
        if (exe_done) begin
            r_status    <= n_status;
            r_index     <= n_index;
            r_offset    <= n_offset_zero ? '0 : offset_raw;
            r_ref_after <= ref_ext[REF_OUT_W-1:0];
            r_released  <= n_released;
            r_err_out   <= n_err;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `RBP_ASSERT(a_wm_in_pool, i_clk, i_rst_n, r_wm <= r_count, "watermark beyond pool size")
    `RBP_ASSERT(a_head_in_pool, i_clk, i_rst_n, !r_head_v || (CNT_W'(r_head) < r_count), "free list head outside the pool")
    `RBP_ASSERT(a_err_on_empty, i_clk, i_rst_n, (n_err != r_err) |-> (exe_done && (n_status == ST_EMPTY)), "error count moved without a failed allocation")
    `RBP_ASSERT(a_push_sets_head, i_clk, i_rst_n, (exe_done && n_released && !i_cfg_we) |=> (r_head_v && (r_head == $past(blk_idx))), "released block not at the head")
    `RBP_NEVER(a_wm_head_order, i_clk, i_rst_n, r_head_v && head_untouched && (r_wm == r_count), "untouched head with no untouched blocks left")

endmodule

`default_nettype wire

### hdl/rbp_ram.sv
// ----------------------------------------------------------------------------
// rbp_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/rbp_offset.sv
// ----------------------------------------------------------------------------
// rbp_offset
// Byte offset of a block's data area inside the pool buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_offset import rbp_pkg::*; #(
    parameter int META_WORDS = DEF_META_WORDS
) (
    input  wire logic [BLOCK_W-1:0]      i_index,
    input  wire logic [ITEM_BYTES_W-1:0] i_item_bytes,
    output      logic [OFFSET_W-1:0]     o_offset
);

    // Payload words need at most eleven bits; with the metadata they are held in twelve.
    localparam int SUM_W   = ITEM_BYTES_W + 1;
    localparam int WORDS_W = 12;
    localparam int PROD_W  = WORDS_W + BLOCK_W;
    localparam int BYTE_W  = PROD_W + 1 + 3;

    logic [SUM_W-1:0]   rounded;
    logic [WORDS_W-1:0] words;
    logic [PROD_W:0]    word_off;
    logic [BYTE_W-1:0]  byte_off;

    always_comb begin
        rounded  = SUM_W'(i_item_bytes) + SUM_W'(7);
        words    = WORDS_W'(rounded >> 3) + WORDS_W'(META_WORDS);
        word_off = (PROD_W + 1)'(i_index) * (PROD_W + 1)'(words)
                 + (PROD_W + 1)'(META_WORDS);
        byte_off = {word_off, 3'b000};
        o_offset = byte_off[OFFSET_W-1:0];
    end

endmodule

`default_nettype wire
